FILE: rtl/core/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int MAX_RESULTS    = 8;
  localparam int FOUND_W        = $clog2(MAX_RESULTS);
  localparam int TICK_W         = 32;
  localparam int SLOT_W         = 3;
  localparam int KIND_W         = 3;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_REG     = 2'd1;
  localparam logic [1:0] CMD_SCAN    = 2'd2;
  localparam logic [1:0] CMD_ELAPSED = 2'd3;

  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REG     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DUE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ELAPSED = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] duration;
  } pts_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
    logic              elapsed_done;
    logic [TICK_W-1:0] tick_now;
    logic              last_of_run;
  } pts_rsp_t;

  // Source of the next result beat loaded into the output register.
  typedef enum logic [1:0] {
    OSEL_EXEC,
    OSEL_PEND_MID,
    OSEL_PEND_LAST,
    OSEL_NONE
  } pts_osel_t;

  typedef struct packed {
    logic      capture;
    logic      exec;
    logic      scan_start;
    logic      rd_en;
    logic      take;
    logic      out_load;
    pts_osel_t out_sel;
  } pts_cmd_t;

  typedef struct packed {
    logic [1:0] req_command;
    logic       chk_valid;
    logic       due;
    logic       pending_valid;
    logic       found_last;
    logic       more_slots;
    logic       out_free;
  } pts_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl
  import pts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  pts_stat_t stat,
  output pts_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  logic stall;
  logic capped;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.out_sel = OSEL_EXEC;
    state_next = state;
    // A due slot must push the held one out, which needs a free output register.
    stall  = stat.chk_valid && stat.due && stat.pending_valid && !stat.out_free;
    capped = stat.chk_valid && stat.due && stat.found_last;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          if (stat.req_command == CMD_SCAN) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.exec     = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_EXEC;
          state_next   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (stat.chk_valid) begin
            cmd.take     = 1'b1;
            cmd.out_load = stat.due && stat.pending_valid;
            cmd.out_sel  = OSEL_PEND_MID;
          end
          cmd.rd_en = stat.more_slots && !capped;
          if (!cmd.rd_en) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = stat.pending_valid ? OSEL_PEND_LAST : OSEL_NONE;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_take_only_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (state == ST_SCAN))
    else $error("slot evaluated outside a scan");

  a_exec_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (state == ST_IDLE))
    else $error("command execution did not return to idle");

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (state == ST_IDLE) && req_valid)
    else $error("request captured outside idle");

endmodule

`default_nettype wire

FILE: rtl/core/pts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pts_datapath
  import pts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  pts_req_t  req,
  output pts_rsp_t  rsp,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  input  pts_cmd_t  cmd,
  output pts_stat_t stat
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);

  pts_req_t                cap;
  logic [TICK_W-1:0]       tick_count;
  logic [TASK_SLOTS-1:0]   slot_used;
  logic [TICK_W-1:0]       period_mem [TASK_SLOTS];
  logic [TICK_W-1:0]       last_mem   [TASK_SLOTS];

  logic [CNT_W-1:0]        scan_idx;
  logic                    chk_valid;
  logic [TICK_W-1:0]       rd_period;
  logic [TICK_W-1:0]       rd_last;
  logic [IDX_W-1:0]        rd_slot;
  logic                    rd_used;
  logic                    pending_valid;
  logic [IDX_W-1:0]        pending_slot;
  logic [FOUND_W-1:0]      found_cnt;

  logic                    free_any;
  logic [IDX_W-1:0]        free_idx;
  logic [IDX_W-1:0]        scan_addr;
  logic [TICK_W-1:0]       slot_elapsed;
  logic [TICK_W-1:0]       req_elapsed;
  logic                    due;
  logic                    reg_write;
  logic                    last_we;
  logic [IDX_W-1:0]        last_addr;
  logic [IDX_W+SLOT_W-1:0] free_ext;
  logic [IDX_W+SLOT_W-1:0] pend_ext;
  logic                    out_free;
  pts_rsp_t                rsp_next;

  // Lowest free slot.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign scan_addr    = scan_idx[IDX_W-1:0];
  assign slot_elapsed = tick_count - rd_last;
  assign req_elapsed  = tick_count - cap.start_tick;
  assign due          = chk_valid && rd_used && (slot_elapsed >= rd_period);
  assign reg_write    = cmd.exec && (cap.command == CMD_REG) && free_any;
  assign last_we      = reg_write || (cmd.take && due);
  assign last_addr    = cmd.take ? rd_slot : free_idx;
  assign free_ext     = {{SLOT_W{1'b0}}, free_idx};
  assign pend_ext     = {{SLOT_W{1'b0}}, pending_slot};
  assign out_free     = !rsp_valid || rsp_ready;

  assign stat.req_command   = req.command;
  assign stat.chk_valid     = chk_valid;
  assign stat.due           = due;
  assign stat.pending_valid = pending_valid;
  assign stat.found_last    = (found_cnt == FOUND_W'(MAX_RESULTS - 1));
  assign stat.more_slots    = (scan_idx < CNT_W'(TASK_SLOTS));
  assign stat.out_free      = out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (reg_write) begin
      period_mem[free_idx] <= cap.period;
    end
    if (last_we) begin
      last_mem[last_addr] <= tick_count;
    end
    if (cmd.rd_en) begin
      rd_period <= period_mem[scan_addr];
      rd_last   <= last_mem[scan_addr];
      rd_slot   <= scan_addr;
      rd_used   <= slot_used[scan_addr];
    end
    if (cmd.take && due) begin
      pending_slot <= rd_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      slot_used     <= '0;
      scan_idx      <= '0;
      chk_valid     <= 1'b0;
      pending_valid <= 1'b0;
      found_cnt     <= '0;
    end else begin
      if (cmd.exec && (cap.command == CMD_TICK)) begin
        tick_count <= tick_count + 32'd1;
      end
      if (reg_write) begin
        slot_used[free_idx] <= 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx      <= '0;
        chk_valid     <= 1'b0;
        pending_valid <= 1'b0;
        found_cnt     <= '0;
      end else begin
        if (cmd.rd_en) begin
          scan_idx  <= scan_idx + CNT_W'(1);
          chk_valid <= 1'b1;
        end else if (cmd.take) begin
          chk_valid <= 1'b0;
        end
        if (cmd.take && due) begin
          pending_valid <= 1'b1;
          found_cnt     <= found_cnt + FOUND_W'(1);
        end
      end
    end
  end

  always_comb begin
    rsp_next              = '0;
    rsp_next.tick_now     = tick_count;
    rsp_next.last_of_run  = 1'b1;
    case (cmd.out_sel)
      OSEL_EXEC: begin
        case (cap.command)
          CMD_TICK: begin
            rsp_next.result_kind = KIND_TICK;
            rsp_next.tick_now    = tick_count + 32'd1;
          end
          CMD_REG: begin
            rsp_next.result_kind = KIND_REG;
            rsp_next.table_full  = !free_any;
            rsp_next.slot        = free_any ? free_ext[SLOT_W-1:0] : '0;
          end
          CMD_ELAPSED: begin
            rsp_next.result_kind  = KIND_ELAPSED;
            rsp_next.elapsed_done = (req_elapsed >= cap.duration);
          end
          default: begin
            rsp_next.result_kind = KIND_NONE;
          end
        endcase
      end
      OSEL_PEND_MID: begin
        rsp_next.result_kind = KIND_DUE;
        rsp_next.slot        = pend_ext[SLOT_W-1:0];
        rsp_next.last_of_run = 1'b0;
      end
      OSEL_PEND_LAST: begin
        rsp_next.result_kind = KIND_DUE;
        rsp_next.slot        = pend_ext[SLOT_W-1:0];
      end
      OSEL_NONE: begin
        rsp_next.result_kind = KIND_NONE;
      end
      default: begin
        rsp_next.result_kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= rsp_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result beat overwritten before it was taken");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> chk_valid)
    else $error("slot evaluated without read data");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (scan_idx < CNT_W'(TASK_SLOTS)))
    else $error("scan read past the last slot");

endmodule

`default_nettype wire

FILE: rtl/core/periodic_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// Periodic task scheduler with a wrapping 32-bit tick counter and a table of
// task slots. Requests arrive on the req channel and results leave on the rsp
// channel; both use valid/ready and move one beat per accepted handshake.
// A tick, register or elapsed-check request has its single result beat loaded
// into the output register in the EXEC state after acceptance, once the register
// is free; req_ready stays low until that load.
// A scan walks the slot table one slot per cycle, unless a stall holds it,
// through the slot memories, whose read data is registered. It emits one beat
// per due slot (at most eight), or one nothing-due beat. A due beat is held
// back until the next due slot is found or the walk ends, so that the final
// beat carries last_of_run.
// req_ready is high only while the controller is idle, even while a finished
// result still waits on rsp. When the receiver stalls, the result stays in the
// output register, and the scan walk pauses at a due slot that must push a held
// beat out, until the register frees up. Synchronous reset clears the tick
// counter, all used marks and the channel state; the period and last-run
// memories are not cleared and only matter for used slots.

module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pts_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pts_rsp_t rsp
);

  // Commands from the controller to the datapath, status back.
  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
